// File: rtl/apq_pkg.sv
// ----------------------------------------------------------------------------
// apq_pkg
// Shared types and codes for the array priority queue.
// ----------------------------------------------------------------------------
package apq_pkg;

   localparam logic KIND_ENQUEUE = 1'b0;
   localparam logic KIND_DEQUEUE = 1'b1;

   localparam logic [1:0] STATUS_DONE      = 2'd0;
   localparam logic [1:0] STATUS_OVERFLOW  = 2'd1;
   localparam logic [1:0] STATUS_UNDERFLOW = 2'd2;

   typedef struct packed {
      logic signed [31:0] value;
      logic signed [31:0] prio;
   } entry_type;

   // broadcast from the controller to every cell
   typedef struct packed {
      logic      insert;
      logic      remove;
      entry_type item;
   } ctl_type;

endpackage

// File: rtl/apq_cell.sv
// ----------------------------------------------------------------------------
// apq_cell
// One slot of the sorted chain. Holds one entry, compares it with the
// broadcast request and shifts down on insert or up on remove.
// ----------------------------------------------------------------------------
module apq_cell (
   input  logic               clock,
   input  apq_pkg::ctl_type   ctl,
   input  logic               held,
   input  logic               prev_stay,
   input  apq_pkg::entry_type prev_entry,
   input  apq_pkg::entry_type next_entry,
   output logic               stay,
   output apq_pkg::entry_type entry
);

   apq_pkg::entry_type entry_ff;
   apq_pkg::entry_type entry_in;

   // held entry ranks ahead of the new one (ties keep insertion order)
   assign stay  = held && (entry_ff.prio >= ctl.item.prio);
   assign entry = entry_ff;

   always_comb begin
      entry_in = entry_ff;
      if (ctl.insert) begin
         if (!stay) begin
            if (prev_stay) begin
               entry_in = ctl.item;
            end else begin
               entry_in = prev_entry;
            end
         end
      end else if (ctl.remove) begin
         entry_in = next_entry;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

endmodule

// File: rtl/array_priority_queue_top.sv
// ----------------------------------------------------------------------------
// array_priority_queue_top
// Bounded max-priority queue built as a sorted chain of cells.
// ----------------------------------------------------------------------------
// Requests arrive on the req_ channel: kind 0 enqueues req_item_value with
// req_item_priority, kind 1 dequeues the highest-priority entry (earliest
// inserted among equal priorities). Each request gives one response on the
// rsp_ channel with status, the removed value and priority (zero unless a
// dequeue succeeded) and the occupancy after the request.
// The cells keep entries sorted by priority, stable in insertion order. An
// enqueue is a broadcast compare in every cell and a one-place shift of the
// lower entries; a dequeue takes the head and shifts all cells up one place.
// Either finishes in the accepting cycle: the response is registered and
// appears in the cycle after acceptance, and a request can be taken every
// cycle while the response register is empty or being drained.
// If the receiver stalls, the response is held and req_ready drops until it
// is taken. Reset empties the queue and clears the response valid flag.
// ----------------------------------------------------------------------------
module array_priority_queue_top #(
   parameter int DEPTH = 64
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic               req_kind,
   input  logic signed [31:0] req_item_value,
   input  logic signed [31:0] req_item_priority,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [1:0]         rsp_status,
   output logic signed [31:0] rsp_removed_value,
   output logic signed [31:0] rsp_removed_priority,
   output logic [6:0]         rsp_occupancy
);

   localparam int CW = $clog2(DEPTH + 1);

   logic [CW-1:0]      count_ff, count_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [1:0]         status_ff, status_in;
   logic signed [31:0] value_ff, value_in;
   logic signed [31:0] prio_ff, prio_in;
   logic [6:0]         occ_ff;
   logic [CW+6:0]      occ_ext;

   logic               accept, full, empty;
   apq_pkg::ctl_type   ctl;

   logic               stay    [DEPTH];
   logic               held    [DEPTH];
   apq_pkg::entry_type entries [DEPTH];

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign full      = (count_ff == CW'(DEPTH));
   assign empty     = (count_ff == '0);

   assign ctl.insert     = accept && (req_kind == apq_pkg::KIND_ENQUEUE) && !full;
   assign ctl.remove     = accept && (req_kind == apq_pkg::KIND_DEQUEUE) && !empty;
   assign ctl.item.value = req_item_value;
   assign ctl.item.prio  = req_item_priority;

   genvar i;
   generate
      for (i = 0; i < DEPTH; i++) begin : g_cell
         assign held[i] = (count_ff > CW'(i));
         if (i == 0) begin : g_head
            apq_cell u_cell (
               .clock      (clock),
               .ctl        (ctl),
               .held       (held[i]),
               .prev_stay  (1'b1),
               .prev_entry (entries[i]),
               .next_entry (entries[i+1]),
               .stay       (stay[i]),
               .entry      (entries[i])
            );
         end else if (i == DEPTH - 1) begin : g_tail
            apq_cell u_cell (
               .clock      (clock),
               .ctl        (ctl),
               .held       (held[i]),
               .prev_stay  (stay[i-1]),
               .prev_entry (entries[i-1]),
               .next_entry (entries[i]),
               .stay       (stay[i]),
               .entry      (entries[i])
            );
         end else begin : g_mid
            apq_cell u_cell (
               .clock      (clock),
               .ctl        (ctl),
               .held       (held[i]),
               .prev_stay  (stay[i-1]),
               .prev_entry (entries[i-1]),
               .next_entry (entries[i+1]),
               .stay       (stay[i]),
               .entry      (entries[i])
            );
         end
      end
   endgenerate

   always_comb begin
      count_in = count_ff;
      if (ctl.insert) begin
         count_in = count_ff + CW'(1);
      end else if (ctl.remove) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_comb begin
      status_in = apq_pkg::STATUS_DONE;
      value_in  = '0;
      prio_in   = '0;
      if (req_kind == apq_pkg::KIND_ENQUEUE) begin
         if (full) begin
            status_in = apq_pkg::STATUS_OVERFLOW;
         end
      end else if (empty) begin
         status_in = apq_pkg::STATUS_UNDERFLOW;
      end else begin
         value_in = entries[0].value;
         prio_in  = entries[0].prio;
      end
   end

   assign occ_ext      = {7'b0, count_in};
   assign rsp_valid_in = accept || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         status_ff <= status_in;
         value_ff  <= value_in;
         prio_ff   <= prio_in;
         occ_ff    <= occ_ext[6:0];
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_status           = status_ff;
   assign rsp_removed_value    = value_ff;
   assign rsp_removed_priority = prio_ff;
   assign rsp_occupancy        = occ_ff;

`ifndef SYNTH
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH))
      else $error("entry count beyond depth");

   a_head_sorted: assert property (@(posedge clock) disable iff (reset)
      held[1] |-> (entries[0].prio >= entries[1].prio))
      else $error("chain head out of priority order");

   a_count_hold: assert property (@(posedge clock) disable iff (reset)
      !accept |=> $stable(count_ff))
      else $error("entry count moved without a request");

   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status != apq_pkg::STATUS_DONE)) |->
         (rsp_removed_value == '0 && rsp_removed_priority == '0))
      else $error("failed request returned an entry");

   a_underflow_empty: assert property (@(posedge clock) disable iff (reset)
      (accept && (req_kind == apq_pkg::KIND_DEQUEUE) && empty) |=>
         (rsp_status == apq_pkg::STATUS_UNDERFLOW && count_ff == '0))
      else $error("empty dequeue changed state");
`endif

endmodule

// File: verif/array_priority_queue_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// array_priority_queue_top_tb
// Self-checking testbench for the bounded max-priority queue.
// ----------------------------------------------------------------------------
// Enqueue and dequeue requests are sent on the req_ channel. A behavioral
// queue held in insertion order predicts every response: the highest priority
// leaves first, the earliest one among equal priorities, with overflow and
// underflow reported. Responses are compared field by field in order.
// Directed cases come first, then fill and drain passes and random bursts
// under three sender and receiver stall mixes.
// ----------------------------------------------------------------------------
module array_priority_queue_top_tb;

   localparam int DEPTH         = 64;
   localparam int CLOCK_PERIOD  = 20;
   localparam int RESET_CYCLES  = 11;
   localparam int WATCHDOG_LIMIT = 5000;
   localparam int DRAIN_CYCLES  = 4;

   typedef struct {
      logic [1:0]         status;
      logic signed [31:0] removed_value;
      logic signed [31:0] removed_priority;
      logic [6:0]         occupancy;
   } response_type;

   typedef enum {MIX_FILL, MIX_DRAIN, MIX_EVEN} mix_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic               req_kind = apq_pkg::KIND_ENQUEUE;
   logic signed [31:0] req_item_value = '0;
   logic signed [31:0] req_item_priority = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic [1:0]         rsp_status;
   logic signed [31:0] rsp_removed_value;
   logic signed [31:0] rsp_removed_priority;
   logic [6:0]         rsp_occupancy;

   apq_pkg::entry_type held_entries[$];
   response_type       pending_responses[$];
   int                 error_count = 0;
   int                 req_gap_pct = 0;
   int                 rsp_stall_pct = 0;
   int                 quiet_cycles = 0;

   array_priority_queue_top #(
      .DEPTH(DEPTH)
   ) u_dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_kind            (req_kind),
      .req_item_value      (req_item_value),
      .req_item_priority   (req_item_priority),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_status          (rsp_status),
      .rsp_removed_value   (rsp_removed_value),
      .rsp_removed_priority(rsp_removed_priority),
      .rsp_occupancy       (rsp_occupancy)
   );

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   function automatic response_type predict_response(logic kind, logic signed [31:0] value,
                                                     logic signed [31:0] prio);
      response_type       r;
      apq_pkg::entry_type e;
      int                 best;
      r.status           = apq_pkg::STATUS_DONE;
      r.removed_value    = '0;
      r.removed_priority = '0;
      if (kind == apq_pkg::KIND_ENQUEUE) begin
         if (held_entries.size() >= DEPTH) begin
            r.status = apq_pkg::STATUS_OVERFLOW;
         end else begin
            e.value = value;
            e.prio  = prio;
            held_entries.push_back(e);
         end
      end else if (held_entries.size() == 0) begin
         r.status = apq_pkg::STATUS_UNDERFLOW;
      end else begin
         best = 0;
         for (int i = 1; i < held_entries.size(); i++) begin
            if ($signed(held_entries[i].prio) > $signed(held_entries[best].prio)) begin
               best = i;
            end
         end
         r.removed_value    = held_entries[best].value;
         r.removed_priority = held_entries[best].prio;
         held_entries.delete(best);
      end
      r.occupancy = 7'(held_entries.size());
      return r;
   endfunction

   function automatic logic signed [31:0] random_priority();
      // narrow range half of the time so equal priorities are common
      if ($urandom_range(1) == 0) begin
         return $signed(32'($urandom_range(7))) - 32'sd4;
      end
      return $urandom;
   endfunction

   task automatic send_request(logic kind, logic signed [31:0] value,
                               logic signed [31:0] prio);
      while ($urandom_range(99) < req_gap_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_kind          <= kind;
      req_item_value    <= value;
      req_item_priority <= prio;
      do @(posedge clock); while (!req_ready);
      pending_responses.push_back(predict_response(kind, value, prio));
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (pending_responses.size() != 0) @(posedge clock);
   endtask

   task automatic test_directed();
      send_request(apq_pkg::KIND_DEQUEUE, 32'sh1234_5678, -32'sd9);
      send_request(apq_pkg::KIND_ENQUEUE, 32'sh7fff_ffff, 32'sh7fff_ffff);
      send_request(apq_pkg::KIND_ENQUEUE, 32'sh8000_0000, 32'sh8000_0000);
      send_request(apq_pkg::KIND_ENQUEUE, 32'sd0, 32'sd0);
      send_request(apq_pkg::KIND_ENQUEUE, -32'sd1, -32'sd1);
      send_request(apq_pkg::KIND_ENQUEUE, 32'sd1, 32'sh7fff_ffff);
      repeat (5) send_request(apq_pkg::KIND_DEQUEUE, $urandom, $urandom);
      send_request(apq_pkg::KIND_DEQUEUE, -32'sd1, -32'sd1);
      send_request(apq_pkg::KIND_ENQUEUE, 32'sd11, 32'sd5);
      send_request(apq_pkg::KIND_ENQUEUE, 32'sd22, 32'sd5);
      send_request(apq_pkg::KIND_ENQUEUE, 32'sd33, 32'sd6);
      send_request(apq_pkg::KIND_ENQUEUE, 32'sd44, 32'sd5);
      repeat (4) send_request(apq_pkg::KIND_DEQUEUE, 32'sd0, 32'sd0);
      send_request(apq_pkg::KIND_DEQUEUE, 32'sd0, 32'sd0);
   endtask

   task automatic test_fill_overflow();
      while (held_entries.size() < DEPTH) begin
         send_request(apq_pkg::KIND_ENQUEUE, $urandom, random_priority());
      end
      repeat (3) send_request(apq_pkg::KIND_ENQUEUE, $urandom, random_priority());
      while (held_entries.size() > 0) begin
         send_request(apq_pkg::KIND_DEQUEUE, $urandom, $urandom);
      end
      repeat (2) send_request(apq_pkg::KIND_DEQUEUE, $urandom, $urandom);
   endtask

   task automatic test_random(int count);
      mix_type mix;
      int      burst;
      int      enq_pct;
      while (count > 0) begin
         mix   = mix_type'($urandom_range(2));
         burst = $urandom_range(16, 96);
         case (mix)
            MIX_FILL:  enq_pct = 80;
            MIX_DRAIN: enq_pct = 20;
            default:   enq_pct = 50;
         endcase
         while (burst > 0 && count > 0) begin
            if ($urandom_range(99) < enq_pct) begin
               send_request(apq_pkg::KIND_ENQUEUE, $urandom, random_priority());
            end else begin
               send_request(apq_pkg::KIND_DEQUEUE, $urandom, $urandom);
            end
            burst--;
            count--;
         end
      end
   endtask

   task automatic check_field(string name, longint want, longint got);
      if (want != got) begin
         error_count++;
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      end
   endtask

   always @(posedge clock) begin : response_check
      response_type want;
      rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_responses.size() == 0) begin
            error_count++;
            $display("%0t: unexpected response, expected none, actual status %0d",
                     $time, rsp_status);
         end else begin
            want = pending_responses.pop_front();
            check_field("status", want.status, rsp_status);
            check_field("removed_value", want.removed_value, rsp_removed_value);
            check_field("removed_priority", want.removed_priority, rsp_removed_priority);
            check_field("occupancy", want.occupancy, rsp_occupancy);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: watchdog expired, %0d responses outstanding",
                     $time, pending_responses.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
         end
      end
   end

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      req_gap_pct   = 11;
      rsp_stall_pct = 77;
      test_directed();
      test_fill_overflow();
      test_random(600);

      req_gap_pct   = 77;
      rsp_stall_pct = 11;
      test_random(600);
      wait_drained();

      req_gap_pct   = 0;
      rsp_stall_pct = 0;
      test_fill_overflow();
      test_random(500);

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (pending_responses.size() != 0) begin
         error_count++;
         $display("%0t: %0d responses never arrived", $time, pending_responses.size());
      end
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
